### rtl/mm4_pkg.sv
// Shared constants for the 4x4 column-major fixed-point matrix multiplier.
// No dependencies; used by matrix_multiply_4x4.
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIM           = 4;
  localparam int unsigned CELLS         = DIM * DIM;
  localparam int unsigned IDX_W         = $clog2(CELLS);
  localparam int unsigned DIM_W         = $clog2(DIM);
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned PROD_W        = 2 * VAL_W;
  // four products summed need two guard bits
  localparam int unsigned ACC_W         = PROD_W + 2;

  localparam logic MODE_A = 1'b0;
  localparam logic MODE_B = 1'b1;

  localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

`default_nettype wire

### rtl/matrix_multiply_4x4.sv
// 4x4 column-major signed fixed-point matrix multiplier, C = A x B.
// Depends on mm4_pkg for sizes and saturation constants.
//
// Each input item writes one element of A (mode 0) or B (mode 1). An item
// with go set also starts the product: the 64 multiply-accumulate steps are
// issued one per cycle, while the result side does not stall, through a
// single 32x32 signed multiplier, behind a registered operand read and a
// registered product, giving the 16 results. in_stall stays high from the
// go item until the sixteenth result is in the output register.
// Both operand stores read as zero after reset until written.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_4x4 #(
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_mode,
  input  wire  [mm4_pkg::IDX_W-1:0]            in_element_index,
  input  wire  signed [mm4_pkg::VAL_W-1:0]     in_element_value,
  input  wire                                  in_go,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [mm4_pkg::IDX_W-1:0]            out_result_index,
  output logic signed [mm4_pkg::VAL_W-1:0]     out_result_value,
  output logic                                 out_overflow,
  output logic                                 out_last
);

  localparam int unsigned IDX_W  = mm4_pkg::IDX_W;
  localparam int unsigned DIM_W  = mm4_pkg::DIM_W;
  localparam int unsigned VAL_W  = mm4_pkg::VAL_W;
  localparam int unsigned PROD_W = mm4_pkg::PROD_W;
  localparam int unsigned ACC_W  = mm4_pkg::ACC_W;
  localparam int unsigned CELLS  = mm4_pkg::CELLS;
  localparam int unsigned CNT_W  = IDX_W + DIM_W;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                     state_r;
  logic [VAL_W-1:0]           mem_a [CELLS];
  logic [VAL_W-1:0]           mem_b [CELLS];
  logic [CELLS-1:0]           vld_a_r, vld_b_r;

  logic [CNT_W-1:0]           cnt_r;
  logic                       issue_done_r;
  logic                       s1_v_r, s2_v_r;
  logic [IDX_W-1:0]           s1_pos_r, s2_pos_r;
  logic [DIM_W-1:0]           s1_k_r, s2_k_r;
  logic signed [VAL_W-1:0]    rd_a_r, rd_b_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_valid_r, out_overflow_r, out_last_r;
  logic [IDX_W-1:0]           out_idx_r;
  logic signed [VAL_W-1:0]    out_val_r;

  logic                       accept, adv, issuing, final_step;
  logic [DIM_W-1:0]           iss_col, iss_row, iss_k;
  logic [IDX_W-1:0]           addr_a, addr_b;
  logic signed [ACC_W-1:0]    acc_base, sum_nxt, shifted;
  logic                       ovf_nxt;
  logic signed [VAL_W-1:0]    res_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // freeze the pipeline while a result waits and the far side stalls
  assign adv      = !(out_valid_r && out_stall);
  assign issuing  = (state_r == ST_RUN) && !issue_done_r;

  assign iss_col  = cnt_r[CNT_W-1 -: DIM_W];
  assign iss_row  = cnt_r[DIM_W +: DIM_W];
  assign iss_k    = cnt_r[DIM_W-1:0];
  assign addr_a   = {iss_k, iss_row};
  assign addr_b   = {iss_col, iss_k};

  assign final_step = s2_v_r && (s2_k_r == DIM_W'(mm4_pkg::DIM - 1));

  always_comb begin
    acc_base = (s2_k_r == '0) ? '0 : acc_r;
    sum_nxt  = acc_base + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    shifted  = sum_nxt >>> FRAC_BITS;
    ovf_nxt  = !((&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]));
    if (!ovf_nxt) begin
      res_nxt = shifted[VAL_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_nxt = mm4_pkg::SAT_MIN;
    end else begin
      res_nxt = mm4_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_mode == mm4_pkg::MODE_A)) begin
      mem_a[in_element_index] <= in_element_value;
    end
    if (accept && (in_mode == mm4_pkg::MODE_B)) begin
      mem_b[in_element_index] <= in_element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vld_a_r      <= '0;
      vld_b_r      <= '0;
      cnt_r        <= '0;
      issue_done_r <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        if (in_mode == mm4_pkg::MODE_A) begin
          vld_a_r[in_element_index] <= 1'b1;
        end else begin
          vld_b_r[in_element_index] <= 1'b1;
        end
        if (in_go) begin
          state_r      <= ST_RUN;
          cnt_r        <= '0;
          issue_done_r <= 1'b0;
        end
      end

      // drop the taken result unless a new one lands this cycle
      if (out_valid_r && !out_stall && !final_step) begin
        out_valid_r <= 1'b0;
      end

      if (adv && (state_r == ST_RUN)) begin
        // operand read
        s1_v_r <= issuing;
        if (issuing) begin
          rd_a_r   <= vld_a_r[addr_a] ? mem_a[addr_a] : '0;
          rd_b_r   <= vld_b_r[addr_b] ? mem_b[addr_b] : '0;
          s1_pos_r <= {iss_col, iss_row};
          s1_k_r   <= iss_k;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == {CNT_W{1'b1}}) begin
            issue_done_r <= 1'b1;
          end
        end
        // multiply
        s2_v_r <= s1_v_r;
        if (s1_v_r) begin
          prod_r   <= rd_a_r * rd_b_r;
          s2_pos_r <= s1_pos_r;
          s2_k_r   <= s1_k_r;
        end
        // accumulate, then shift down (floor) and saturate on the last term
        if (s2_v_r) begin
          acc_r <= sum_nxt;
        end
        if (final_step) begin
          out_valid_r    <= 1'b1;
          out_idx_r      <= s2_pos_r;
          out_val_r      <= res_nxt;
          out_overflow_r <= ovf_nxt;
          out_last_r     <= (s2_pos_r == IDX_W'(CELLS - 1));
          if (s2_pos_r == IDX_W'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_result_value = out_val_r;
  assign out_overflow     = out_overflow_r;
  assign out_last         = out_last_r;

  a_go_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_go) |=> in_stall)
    else $error("go item did not start the product");

  a_pipe_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r) |-> (state_r == ST_RUN))
    else $error("pipeline busy outside a product");

  a_last_drains_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (!s1_v_r && !s2_v_r))
    else $error("work left after the last result");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_overflow_r) |->
      (out_val_r == mm4_pkg::SAT_MAX || out_val_r == mm4_pkg::SAT_MIN))
    else $error("overflow flagged without saturation");

endmodule

`default_nettype wire

### verif/mm4_checker.sv
// Result checker for matrix_multiply_4x4: mirrors both operand stores, predicts
// every product element and compares the result channel against it in order.
// Depends on mm4_pkg for sizes, mode codes and saturation limits.
`timescale 1ns / 1ps

module mm4_checker
  import mm4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     in_stall,
  input  wire                     in_mode,
  input  wire [IDX_W-1:0]         in_element_index,
  input  wire signed [VAL_W-1:0]  in_element_value,
  input  wire                     in_go,
  input  wire                     out_valid,
  input  wire                     out_stall,
  input  wire [IDX_W-1:0]         out_result_index,
  input  wire signed [VAL_W-1:0]  out_result_value,
  input  wire                     out_overflow,
  input  wire                     out_last,
  output int                      mismatches,
  output int                      pending
);

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    overflow;
    logic                    last;
  } product_elem_t;

  logic signed [VAL_W-1:0] store_a [CELLS];
  logic signed [VAL_W-1:0] store_b [CELLS];
  product_elem_t           product_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic product_elem_t product_element(int col, int row);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    product_elem_t           elem;
    acc = '0;
    // full-width sum, operands sign-extend to the accumulator width
    for (int k = 0; k < DIM; k++)
      acc = acc + store_a[k * DIM + row] * store_b[col * DIM + k];
    scaled = acc >>> FRAC_BITS;
    elem.index = IDX_W'(col * DIM + row);
    elem.last  = (col * DIM + row == CELLS - 1);
    if (scaled > SAT_MAX) begin
      elem.value    = SAT_MAX;
      elem.overflow = 1'b1;
    end else if (scaled < SAT_MIN) begin
      elem.value    = SAT_MIN;
      elem.overflow = 1'b1;
    end else begin
      elem.value    = scaled[VAL_W-1:0];
      elem.overflow = 1'b0;
    end
    return elem;
  endfunction

  task automatic check_result();
    product_elem_t want;
    if (product_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, got idx %0d val %h ovf %b last %b", $time,
               out_result_index, out_result_value, out_overflow, out_last);
      return;
    end
    want = product_q.pop_front();
    if (out_result_index !== want.index || out_result_value !== want.value ||
        out_overflow !== want.overflow || out_last !== want.last) begin
      mismatches++;
      $display("%0t: expected idx %0d val %h ovf %b last %b, got idx %0d val %h ovf %b last %b",
               $time, want.index, want.value, want.overflow, want.last,
               out_result_index, out_result_value, out_overflow, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        store_a[i] = '0;
        store_b[i] = '0;
      end
      product_q.delete();
    end else begin
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_B)
          store_b[in_element_index] = in_element_value;
        else
          store_a[in_element_index] = in_element_value;
        // the go item's own element is already in place
        if (in_go)
          for (int col = 0; col < DIM; col++)
            for (int row = 0; row < DIM; row++)
              product_q.push_back(product_element(col, row));
      end
    end
    pending = product_q.size();
  end

endmodule

### verif/tb.sv
// Testbench top for matrix_multiply_4x4: drives element loads and products,
// varies input gaps and result-side stalls and reports the verdict.
// Depends on mm4_pkg, matrix_multiply_4x4 and mm4_checker.
`timescale 1ns / 1ps

module tb;
  import mm4_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_mode;
  logic [IDX_W-1:0]        in_element_index;
  logic signed [VAL_W-1:0] in_element_value;
  logic                    in_go;
  logic                    out_valid;
  logic                    out_stall;
  logic [IDX_W-1:0]        out_result_index;
  logic signed [VAL_W-1:0] out_result_value;
  logic                    out_overflow;
  logic                    out_last;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int idle_cycles;

  matrix_multiply_4x4 dut (.*);

  mm4_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: long hold when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic mode, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val, logic go);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_element_index <= idx;
    in_element_value <= val;
    in_go            <= go;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] random_element();
    int v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 0;
          3: v = 32'h0001_0000;
          4: v = -1;
          default: v = 1;
        endcase
      end
      1, 2: v = $urandom();
      3, 4, 5: v = $urandom_range(0, 32'h001F_FFFF) - (1 << 20);
      default: v = $urandom_range(0, 32'h01FF_FFFF) - (1 << 24);
    endcase
    return v;
  endfunction

  task automatic send_random(int count);
    repeat (count)
      send_item(1'($urandom_range(1)), IDX_W'($urandom_range(CELLS - 1)),
                random_element(), $urandom_range(7) == 0);
  endtask

  // always step to a negedge first so in_valid is not driven twice at once
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_A;
    in_element_index = '0;
    in_element_value = '0;
    in_go            = 1'b0;
    out_stall        = 1'b0;
    hold_left        = 0;
    idle_cycles      = 0;
    send_idle_pct    = 32;
    recv_idle_pct    = 61;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // product right after reset: B still clear, all zero
    send_item(MODE_A, 0, 32'h0001_0000, 1'b1);
    // identity A against extreme diagonal B
    send_item(MODE_A, 5, 32'h0001_0000, 1'b0);
    send_item(MODE_A, 10, 32'h0001_0000, 1'b0);
    send_item(MODE_A, 15, 32'h0001_0000, 1'b0);
    send_item(MODE_B, 0, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_B, 5, 32'h8000_0000, 1'b0);
    send_item(MODE_B, 10, 32'hFFFF_FFFF, 1'b0);
    send_item(MODE_B, 15, 32'h0001_8000, 1'b1);
    // saturate high on element 0, low on element 5
    send_item(MODE_A, 0, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_A, 5, 32'h7FFF_FFFF, 1'b1);
    // tiny negative product must round down to -1
    send_item(MODE_A, 10, 32'h0000_0001, 1'b1);
    // four products of most-negative operands summed on the last element
    send_item(MODE_A, 3, 32'h8000_0000, 1'b0);
    send_item(MODE_A, 7, 32'h8000_0000, 1'b0);
    send_item(MODE_A, 11, 32'h8000_0000, 1'b0);
    send_item(MODE_A, 15, 32'h8000_0000, 1'b0);
    send_item(MODE_B, 12, 32'h8000_0000, 1'b0);
    send_item(MODE_B, 13, 32'h8000_0000, 1'b0);
    send_item(MODE_B, 14, 32'h8000_0000, 1'b0);
    send_item(MODE_B, 15, 32'h8000_0000, 1'b1);
    send_item(MODE_B, 15, 32'h0000_0000, 1'b1);

    send_random(90);
    in_valid <= 1'b0;
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 32;
    send_random(85);
    in_valid <= 1'b0;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side while two products are offered back to back
    @(posedge clk);
    hold_left = LONG_HOLD;
    @(negedge clk);
    repeat (2) begin
      repeat (4)
        send_item(1'($urandom_range(1)), IDX_W'($urandom_range(CELLS - 1)),
                  random_element(), 1'b0);
      send_item(1'($urandom_range(1)), IDX_W'($urandom_range(CELLS - 1)),
                random_element(), 1'b1);
    end
    send_random(75);
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/mm4_pkg.sv
rtl/matrix_multiply_4x4.sv
verif/mm4_checker.sv
verif/tb.sv
